// ----- sv/fcfb_pkg.sv -----
// ----------------------------------------------------------------------------
// fcfb_pkg
// Types and constants shared by the command frame builder modules.
// ----------------------------------------------------------------------------
package fcfb_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CFG_START_CODE     = 8'd0;
    localparam logic [7:0] CFG_DEVICE_ADDRESS = 8'd1;

    localparam logic [15:0] LEN_OVERHEAD = 16'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [8:0] payload_len;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  ptype;
        logic [15:0] len;
        logic [15:0] csum;
        logic        first;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_qstat;

endpackage

// ----- sv/fcfb_front.sv -----
// ----------------------------------------------------------------------------
// fcfb_front
// Accepts requests, forms the length field and keeps the running checksum.
// ----------------------------------------------------------------------------
module fcfb_front import fcfb_pkg::*; #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [15:0] plen;
    logic [15:0] len;
    logic [15:0] base;
    logic [15:0] csum;

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

    always_comb begin
        plen = {7'd0, i_in_item.payload_len};
        if (plen > MaxLen) begin
            plen = MaxLen;
        end
        len  = plen + LEN_OVERHEAD;
        base = i_in_item.first_byte
             ? ({8'd0, i_in_item.packet_type} + {8'd0, len[15:8]} + {8'd0, len[7:0]})
             : r_sum;
        csum = base + {8'd0, i_in_item.payload_byte};
        n_sum = r_sum;
        if (o_push) begin
            n_sum = i_in_item.last_byte ? 16'd0 : csum;
        end
    end

    always_comb begin
        o_cmd.data  = i_in_item.payload_byte;
        o_cmd.ptype = i_in_item.packet_type;
        o_cmd.len   = len;
        o_cmd.csum  = csum;
        o_cmd.first = i_in_item.first_byte;
        o_cmd.last  = i_in_item.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 16'd0;
        end else begin
            r_sum <= n_sum;
        end
    end

`ifndef SYNTH
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_in_item.last_byte) |=> (r_sum == 16'd0))
        else $error("checksum not cleared after last byte");
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> $stable(r_sum))
        else $error("checksum changed without a request");
    a_sum_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !i_in_item.last_byte) |=> (r_sum == $past(csum)))
        else $error("checksum not carried forward");
`endif

endmodule

// ----- sv/fcfb_queue.sv -----
// ----------------------------------------------------------------------------
// fcfb_queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module fcfb_queue import fcfb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.ready = (r_count != QCNT_W'(QDEPTH));
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_stat.ready)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.valid)
        else $error("pop from an empty queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- sv/fcfb_back.sv -----
// ----------------------------------------------------------------------------
// fcfb_back
// Sequences header, payload and checksum bytes into the output register.
// ----------------------------------------------------------------------------
module fcfb_back import fcfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [15:0] i_start_code,
    input  logic [31:0] i_device_address,
    input  t_qstat    i_qstat,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam logic [3:0] STEP_SC_HI  = 4'd0;
    localparam logic [3:0] STEP_SC_LO  = 4'd1;
    localparam logic [3:0] STEP_AD_3   = 4'd2;
    localparam logic [3:0] STEP_AD_2   = 4'd3;
    localparam logic [3:0] STEP_AD_1   = 4'd4;
    localparam logic [3:0] STEP_AD_0   = 4'd5;
    localparam logic [3:0] STEP_TYPE   = 4'd6;
    localparam logic [3:0] STEP_LEN_HI = 4'd7;
    localparam logic [3:0] STEP_LEN_LO = 4'd8;
    localparam logic [3:0] STEP_DATA   = 4'd9;
    localparam logic [3:0] STEP_CS_HI  = 4'd10;
    localparam logic [3:0] STEP_CS_LO  = 4'd11;

    logic       r_busy;
    logic [3:0] r_step;
    t_cmd       r_cmd;
    logic       r_out_valid;
    t_out_item  r_out;

    t_cmd       cur;
    logic [3:0] cur_step;
    logic [3:0] next_step;
    logic       done;
    logic       have;
    logic       adv;
    logic [7:0] byte_val;

    assign adv  = !r_out_valid || i_out_ready;
    assign have = r_busy || i_qstat.valid;
    assign cur  = r_busy ? r_cmd : i_cmd;
    assign cur_step = r_busy ? r_step : (i_cmd.first ? STEP_SC_HI : STEP_DATA);
    assign o_pop = adv && !r_busy && i_qstat.valid;

    always_comb begin
        unique case (cur_step)
            STEP_SC_HI:  byte_val = i_start_code[15:8];
            STEP_SC_LO:  byte_val = i_start_code[7:0];
            STEP_AD_3:   byte_val = i_device_address[31:24];
            STEP_AD_2:   byte_val = i_device_address[23:16];
            STEP_AD_1:   byte_val = i_device_address[15:8];
            STEP_AD_0:   byte_val = i_device_address[7:0];
            STEP_TYPE:   byte_val = cur.ptype;
            STEP_LEN_HI: byte_val = cur.len[15:8];
            STEP_LEN_LO: byte_val = cur.len[7:0];
            STEP_DATA:   byte_val = cur.data;
            STEP_CS_HI:  byte_val = cur.csum[15:8];
            STEP_CS_LO:  byte_val = cur.csum[7:0];
            default:     byte_val = 8'd0;
        endcase
    end

    always_comb begin
        done      = 1'b0;
        next_step = cur_step + 4'd1;
        unique case (cur_step)
            STEP_DATA:  done = !cur.last;
            STEP_CS_LO: done = 1'b1;
            default:    done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv && have) begin
            r_out.frame_byte <= byte_val;
            r_out.frame_end  <= (cur_step == STEP_CS_LO);
            r_cmd            <= cur;
            r_step           <= next_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= have;
            if (have) begin
                r_busy <= !done;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step != STEP_SC_HI && r_step <= STEP_CS_LO))
        else $error("sequencer step out of range");
    a_end_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && have) |=> (o_out_item.frame_end == ($past(cur_step) == STEP_CS_LO)))
        else $error("frame end marker on the wrong byte");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("queue popped while a request is in progress");
`endif

endmodule

// ----- sv/fingerprint_command_frame_builder.sv -----
// ----------------------------------------------------------------------------
// fingerprint_command_frame_builder
// Builds sensor command frames: header, payload bytes and 16-bit checksum.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_item (t_in_item)
// out      output     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One output byte leaves per cycle from the back sequencer unless the output
// stalls: a data byte, plus 9 header bytes if first and 2 csum bytes if last.
// Mid-frame payload requests flow at one per cycle unless the output stalls.
// A four-entry queue lets the input side run ahead of output stalls.
// Reset is synchronous and active low; it restores the register defaults.
// ----------------------------------------------------------------------------
module fingerprint_command_frame_builder import fcfb_pkg::*; #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0] r_start_code;
    logic [31:0] r_device_address;

    logic   push;
    logic   pop;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code     <= 16'hEF01;
            r_device_address <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_START_CODE) begin
                r_start_code <= i_cfg_data[15:0];
            end
            if (i_cfg_index == CFG_DEVICE_ADDRESS) begin
                r_device_address <= i_cfg_data;
            end
        end
    end

    fcfb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_ready  (qstat.ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    fcfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    fcfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start_code     (r_start_code),
        .i_device_address (r_device_address),
        .i_qstat          (qstat),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_item       (o_out_item)
    );

endmodule
